### hw/rtl/sbpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpb_pkg: shared types and constants of the slack-bounded packet buffer
// Holds the built sizes, the packet key type and the cell row command codes.
// ----------------------------------------------------------------------------
package sbpb_pkg;

  localparam int DEPTH      = 64;
  localparam int SLACK_BITS = 16;
  localparam int VALUE_BITS = 16;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef struct packed {
    logic [SLACK_BITS-1:0] slack;
    logic [VALUE_BITS-1:0] value;
  } key_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [1:0] {
    OP_HOLD      = 2'd0,
    OP_INSERT    = 2'd1,
    OP_SHIFT     = 2'd2,
    OP_SHIFT_DEC = 2'd3
  } op_t;

  typedef struct packed {
    op_t  op;
    key_t key;
  } row_cmd_t;

endpackage : sbpb_pkg
`default_nettype wire

### hw/rtl/slack_bounded_packet_buffer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slack_bounded_packet_buffer_top: earliest-deadline-first bounded buffer
// Arrivals insert copies of a packet into a sorted cell row; ticks age,
// expire and transmit packets. One result word is produced per input word.
// ----------------------------------------------------------------------------
// An arrival word inserts each copy into the row in turn; a copy that finds
// the buffer full either shifts out the head and is then inserted, or is
// rejected. A tick shifts out each expired head, then transmits the head and
// ages the rest. One word is in work at a time; the next word is accepted as
// soon as the row is idle, while the previous result may still wait in the
// output register. Reset clears all cells, counters and the capacity
// (to 64); there is no clearing pass.
// ----------------------------------------------------------------------------
module slack_bounded_packet_buffer_top import sbpb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration: queue_capacity.
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,
  // Input stream.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // s_tdata fields from bit 0: copies[7:0], slack[23:8], value[39:24].
  input  wire logic [39:0]  s_tdata,
  // s_tuser fields from bit 0: kind (0 = arrival, 1 = tick).
  input  wire logic [0:0]   s_tuser,
  // Output stream.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // m_tdata fields from bit 0: sent_value[15:0], arrived_total[47:16],
  // dropped_total[79:48], sent_total[111:80], value_total[143:112],
  // occupancy[150:144], one zero pad bit.
  output logic [151:0]      m_tdata,
  // m_tuser fields from bit 0: sent.
  output logic [0:0]        m_tuser
);

  localparam int CAP_W     = 7;
  localparam int OCC_W     = 7;
  localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int TOT_W     = 32;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ARRIVE = 6'b000010,
    ST_EVICT  = 6'b000100,
    ST_EXPIRE = 6'b001000,
    ST_TX     = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  function automatic logic [TOT_W-1:0] sat_add(input logic [TOT_W-1:0] a,
                                               input logic [TOT_W-1:0] b);
    logic [TOT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TOT_W] ? {TOT_W{1'b1}} : s[TOT_W-1:0];
  endfunction

  state_t            state;
  logic [CAP_W-1:0]  queue_capacity;
  logic [CNT_W-1:0]  count;
  logic [7:0]        copies_left;
  key_t              new_key;
  logic [TOT_W-1:0]  arrived_count;
  logic [TOT_W-1:0]  dropped_count;
  logic [TOT_W-1:0]  sent_count;
  logic [TOT_W-1:0]  sent_value_sum;
  logic              res_sent;
  logic [VALUE_BITS-1:0] res_value;

  row_cmd_t          cmd;
  logic              head_valid;
  key_t              head_key;

  logic [CMP_W-1:0]  cap_wide;
  logic [CNT_W-1:0]  cap_eff;
  logic [CMP_W-1:0]  occ_wide;
  logic              has_room;
  logic              can_evict;
  logic              head_expires;
  logic              in_accept;

  // The effective capacity is the written capacity clipped to the built depth.
  assign cap_wide = CMP_W'(queue_capacity);
  assign cap_eff  = (cap_wide >= CMP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_wide);

  // A full buffer takes the new packet only if the head's slack is smaller.
  assign has_room     = count < cap_eff;
  assign can_evict    = head_valid && (head_key.slack < new_key.slack);
  assign head_expires = head_valid && (head_key.slack <= SLACK_BITS'(1));

  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Row command for this cycle.
  always_comb begin
    cmd.key = new_key;
    cmd.op  = OP_HOLD;
    unique case (state)
      ST_ARRIVE: begin
        if (copies_left != 8'd0) begin
          if (has_room) begin
            cmd.op = OP_INSERT;
          end else if (can_evict) begin
            cmd.op = OP_SHIFT;
          end
        end
      end
      ST_EVICT: begin
        cmd.op = OP_INSERT;
      end
      ST_EXPIRE: begin
        if (head_expires) begin
          cmd.op = OP_SHIFT;
        end
      end
      ST_TX: begin
        // Every packet left has slack above one, so all may be decremented.
        if (head_valid) begin
          cmd.op = OP_SHIFT_DEC;
        end
      end
      default: begin
      end
    endcase
  end

  sbpb_row u_row (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .head_valid (head_valid),
    .head_key   (head_key)
  );

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      copies_left   <= s_tdata[7:0];
      new_key.slack <= s_tdata[8 +: SLACK_BITS];
      new_key.value <= s_tdata[24 +: VALUE_BITS];
      res_sent      <= 1'b0;
      res_value     <= '0;
    end
    if (state == ST_ARRIVE && copies_left != 8'd0) begin
      copies_left <= copies_left - 8'd1;
    end
    if (state == ST_TX && head_valid) begin
      res_sent  <= 1'b1;
      res_value <= head_key.value;
    end
  end

  assign occ_wide = CMP_W'(count);

  // Control, counters and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      queue_capacity <= CAP_W'(64);
      count          <= '0;
      arrived_count  <= '0;
      dropped_count  <= '0;
      sent_count     <= '0;
      sent_value_sum <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (cfg_we) begin
        queue_capacity <= cfg_wdata;
      end
      // A finished word loads the output register when it is free or being
      // taken; otherwise a taken word empties it.
      if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            state <= s_tuser[0] ? ST_EXPIRE : ST_ARRIVE;
          end
        end
        ST_ARRIVE: begin
          if (copies_left == 8'd0) begin
            state <= ST_FINISH;
          end else begin
            arrived_count <= sat_add(arrived_count, TOT_W'(1));
            if (has_room) begin
              count <= count + CNT_W'(1);
            end else begin
              // Rejected copy or evicted head: one packet is dropped either way.
              dropped_count <= sat_add(dropped_count, TOT_W'(1));
              if (can_evict) begin
                state <= ST_EVICT;
              end
            end
          end
        end
        ST_EVICT: begin
          state <= ST_ARRIVE;
        end
        ST_EXPIRE: begin
          if (head_expires) begin
            count         <= count - CNT_W'(1);
            dropped_count <= sat_add(dropped_count, TOT_W'(1));
          end else begin
            state <= ST_TX;
          end
        end
        ST_TX: begin
          if (head_valid) begin
            count          <= count - CNT_W'(1);
            sent_count     <= sat_add(sent_count, TOT_W'(1));
            sent_value_sum <= sat_add(sent_value_sum, TOT_W'(head_key.value));
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, occ_wide[OCC_W-1:0], sent_value_sum, sent_count,
                  dropped_count, arrived_count, 16'(res_value)};
      m_tuser <= res_sent;
    end
  end

  // The occupancy counter never runs past the row length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("occupancy counter exceeds row depth");

  // The head cell is filled exactly when the counter says packets are held.
  // Between the two steps of an eviction the row holds one packet fewer.
  a_head_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state != ST_EVICT) |-> ((count != '0) == head_valid))
    else $error("head cell disagrees with occupancy counter");

  // After the expiry sweep no transmitted packet has slack of one or less.
  a_tx_not_expired: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TX && head_valid) |-> (head_key.slack > SLACK_BITS'(1)))
    else $error("transmitting a packet that should have expired");

  // An insert of a fresh copy always finds a free cell.
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ARRIVE && cmd.op == OP_INSERT) |-> (count < CNT_W'(DEPTH)))
    else $error("insert into a full row");

endmodule : slack_bounded_packet_buffer_top
`default_nettype wire

### hw/rtl/sbpb_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpb_cell: one slot of the sorted packet row
// Keeps, takes the new packet, or takes a neighbor's packet on each command.
// ----------------------------------------------------------------------------
module sbpb_cell import sbpb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire row_cmd_t cmd,
  input  wire logic     left_stay,
  input  wire logic     left_valid,
  input  wire key_t     left_key,
  input  wire logic     right_valid,
  input  wire key_t     right_key,
  output logic          valid,
  output key_t          key,
  output logic          stay
);

  logic new_less;

  assign new_less = (cmd.key.slack < key.slack) ||
                    ((cmd.key.slack == key.slack) && (cmd.key.value < key.value));
  // A cell stays put during an insert when its packet does not sort after the new one.
  assign stay = valid && !new_less;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_INSERT: begin
        if (!stay) begin
          if (left_stay) begin
            key <= cmd.key;
          end else begin
            key <= left_key;
          end
        end
      end
      OP_SHIFT: begin
        key <= right_key;
      end
      OP_SHIFT_DEC: begin
        key.slack <= right_key.slack - SLACK_BITS'(1);
        key.value <= right_key.value;
      end
      default: begin
      end
    endcase
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (!stay) begin
            valid <= left_stay ? 1'b1 : left_valid;
          end
        end
        OP_SHIFT, OP_SHIFT_DEC: begin
          valid <= right_valid;
        end
        default: begin
        end
      endcase
    end
  end

endmodule : sbpb_cell
`default_nettype wire

### hw/rtl/sbpb_row.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbpb_row: chain of cells kept in ascending (slack, value) order
// Cell zero always holds the smallest packet; empty cells sit at the far end.
// ----------------------------------------------------------------------------
module sbpb_row import sbpb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire row_cmd_t cmd,
  output logic          head_valid,
  output key_t          head_key
);

  logic cell_valid [DEPTH];
  key_t cell_key   [DEPTH];
  logic cell_stay  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic l_stay;
    logic l_valid;
    key_t l_key;
    logic r_valid;
    key_t r_key;

    if (i == 0) begin : g_first
      assign l_stay  = 1'b1;
      assign l_valid = 1'b0;
      assign l_key   = '0;
    end else begin : g_inner
      assign l_stay  = cell_stay[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_key   = cell_key[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_valid = 1'b0;
      assign r_key   = '0;
    end else begin : g_link
      assign r_valid = cell_valid[i+1];
      assign r_key   = cell_key[i+1];
    end

    sbpb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_stay   (l_stay),
      .left_valid  (l_valid),
      .left_key    (l_key),
      .right_valid (r_valid),
      .right_key   (r_key),
      .valid       (cell_valid[i]),
      .key         (cell_key[i]),
      .stay        (cell_stay[i])
    );
  end

  assign head_valid = cell_valid[0];
  assign head_key   = cell_key[0];

endmodule : sbpb_row
`default_nettype wire
